[design/ujfr_pkg.sv]
// Shared types, codes and constants of the frame receiver.
package ujfr_pkg;

  localparam int MAX_IMAGE_BYTES_DEF = 65536;
  localparam logic [16:0] MIN_FRAME_LEN_RST = 17'd500;

  localparam logic [7:0] SYNC_BYTE_A = 8'hAA;
  localparam logic [7:0] SYNC_BYTE_B = 8'h55;
  localparam logic [7:0] SOI_BYTE_0  = 8'hFF;
  localparam logic [7:0] SOI_BYTE_1  = 8'hD8;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_BADLEN   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_NOTJPEG  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_SYNC = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  // Outcome of one request, as the result register takes it.
  typedef struct packed {
    status_t     status;
    logic        ready;
    logic [16:0] length;
  } step_res_t;

  // Sync word AA 55 AA 55: even positions AA, odd 55.
  function automatic logic [7:0] sync_byte(input logic [1:0] pos);
    sync_byte = pos[0] ? SYNC_BYTE_B : SYNC_BYTE_A;
  endfunction

endpackage

[design/ujfr_if.sv]
// Request and result channel interfaces of the frame receiver.
interface ujfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  rx_byte;
  logic [15:0] read_address;

  modport source (output valid, command, rx_byte, read_address, input ready);
  modport sink   (input valid, command, rx_byte, read_address, output ready);
endinterface

interface ujfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        image_ready;
  logic [16:0] image_length;
  logic [7:0]  read_data;

  modport source (output valid, status, image_ready, image_length, read_data,
                  input ready);
  modport sink   (input valid, status, image_ready, image_length, read_data,
                  output ready);
endinterface

[design/uart_jpeg_frame_receiver_unit.sv]
// Top level of the sync-word, length-prefixed JPEG frame receiver.
// Usage:
//  - in_chan carries one request per transfer: command 0 feeds a received
//    serial byte to the deframer, 1 clears the image-ready flag, 2 reads
//    a stored image byte at read_address (zero when beyond the buffer).
//  - out_chan returns exactly one result per request, in order: status,
//    image_ready, image_length and read_data.
//  - cfg_wr_en/cfg_wr_data write min_frame_length; write only when idle.
// Timing:
//  - one request per cycle sustained while out_chan accepts results; a
//    request passes through the input register, then the result register
//    (the buffer read port is registered into the result stage).
// Reset (rst_n low, synchronous): parser back to sync hunt, flags and
//  lengths cleared, min_frame_length back to 500. Buffer contents are not
//  cleared and read as undefined until written; no clearing pass.
// Stall: while out_chan is held off, the result register holds, one more
//  request is taken into the input register, then in_chan.ready drops.
module uart_jpeg_frame_receiver_unit #(
  parameter int MAX_IMAGE_BYTES = ujfr_pkg::MAX_IMAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ujfr_in_if.sink     in_chan,
  ujfr_out_if.source  out_chan,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  import ujfr_pkg::*;

  localparam int AW  = $clog2(MAX_IMAGE_BYTES);
  localparam int CW  = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int RAW = (AW > 16) ? AW : 16;   // read address compare width

  // config
  logic [16:0] min_len_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  cmd_t        s1_cmd_r;
  logic [7:0]  s1_byte_r;
  logic [15:0] s1_addr_r;

  // result register
  logic        out_valid_r;
  step_res_t   res_r;
  logic        rd_sel_r;

  logic        advance;     // result stage free to load
  logic        step_en;     // request in input register is processed
  logic        in_take;
  step_res_t   res;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]  wr_data;
  logic [RAW:0] addr_ext;
  logic        rd_sel;
  logic [7:0]  rd_data;

  assign advance  = !out_valid_r || out_chan.ready;
  assign step_en  = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_FRAME_LEN_RST;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // input register
  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= cmd_t'(in_chan.command);
      s1_byte_r <= in_chan.rx_byte;
      s1_addr_r <= in_chan.read_address;
    end
  end

  ujfr_parser #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
    .AW              (AW),
    .CW              (CW)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (step_en),
    .cmd     (s1_cmd_r),
    .rx_byte (s1_byte_r),
    .min_len (min_len_r),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // read only inside the buffer; otherwise the result carries zero
  assign addr_ext = (RAW + 1)'(s1_addr_r);
  assign rd_sel   = (s1_cmd_r == CMD_READ) &&
                    (addr_ext < (RAW + 1)'(MAX_IMAGE_BYTES));

  ujfr_store #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
    .AW              (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (step_en && rd_sel),
    .rd_addr (addr_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r    <= res;
      rd_sel_r <= rd_sel;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = res_r.status;
  assign out_chan.image_ready  = res_r.ready;
  assign out_chan.image_length = res_r.length;
  assign out_chan.read_data    = rd_sel_r ? rd_data : 8'd0;

  // an accepted frame always leaves the ready flag set
  a_accept_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status == ST_ACCEPT |-> res_r.ready)
    else $error("frame accepted without image ready");

  // a request waiting in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("pending request lost");

  // only byte requests produce a non-zero status
  a_status_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && s1_cmd_r != CMD_BYTE |=> res_r.status == ST_NONE)
    else $error("status from a non-byte request");

endmodule

[design/ujfr_store.sv]
// Image buffer: one write port, one registered read port.
module ujfr_store #(
  parameter int MAX_IMAGE_BYTES = ujfr_pkg::MAX_IMAGE_BYTES_DEF,
  parameter int AW = $clog2(MAX_IMAGE_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MAX_IMAGE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/ujfr_parser.sv]
// Sync hunt, length capture, payload count and image-ready bookkeeping.
module ujfr_parser #(
  parameter int MAX_IMAGE_BYTES = ujfr_pkg::MAX_IMAGE_BYTES_DEF,
  parameter int AW = $clog2(MAX_IMAGE_BYTES),
  parameter int CW = $clog2(MAX_IMAGE_BYTES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  ujfr_pkg::cmd_t      cmd,
  input  logic [7:0]          rx_byte,
  input  logic [16:0]         min_len,
  output ujfr_pkg::step_res_t res,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data
);
  import ujfr_pkg::*;

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_IMAGE_BYTES);
  localparam logic [31:0]   LEN_MAX = 32'(MAX_IMAGE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  sync_cnt_r, sync_cnt_nxt;
  logic [1:0]  len_idx_r, len_idx_nxt;
  logic [31:0] ann_len_r, ann_len_nxt;
  logic [CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic        ready_r, ready_nxt;
  logic [16:0] stored_len_r, stored_len_nxt;
  // copies of buffer offsets 0 and 1 for the start-of-image check
  logic [7:0]  byte0_r, byte0_nxt;
  logic [7:0]  byte1_r, byte1_nxt;
  logic [CW-1:0] cnt_inc;
  status_t     status;
  logic        wr;

  assign cnt_inc = rx_cnt_r + CW'(1);

  always_comb begin
    phase_nxt      = phase_r;
    sync_cnt_nxt   = sync_cnt_r;
    len_idx_nxt    = len_idx_r;
    ann_len_nxt    = ann_len_r;
    rx_cnt_nxt     = rx_cnt_r;
    ready_nxt      = ready_r;
    stored_len_nxt = stored_len_r;
    byte0_nxt      = byte0_r;
    byte1_nxt      = byte1_r;
    status         = ST_NONE;
    wr             = 1'b0;
    unique case (cmd)
      CMD_BYTE: begin
        unique case (phase_r)
          PH_LEN: begin
            ann_len_nxt[{len_idx_r, 3'b000} +: 8] = rx_byte;
            len_idx_nxt = len_idx_r + 2'd1;
            if (len_idx_r == 2'd3) begin
              if (ann_len_nxt < 32'(min_len) || ann_len_nxt > LEN_MAX) begin
                status    = ST_BADLEN;
                phase_nxt = PH_SYNC;
              end else begin
                rx_cnt_nxt = '0;
                phase_nxt  = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            wr         = !ready_r;
            rx_cnt_nxt = cnt_inc;
            if (wr && rx_cnt_r == CW'(0)) begin
              byte0_nxt = rx_byte;
            end
            if (wr && rx_cnt_r == CW'(1)) begin
              byte1_nxt = rx_byte;
            end
            if (cnt_inc == CNT_MAX) begin
              status    = ST_OVERFLOW;
              phase_nxt = PH_SYNC;
            end else if (32'(cnt_inc) >= ann_len_r) begin
              if (!ready_r) begin
                if (byte0_nxt == SOI_BYTE_0 && byte1_nxt == SOI_BYTE_1) begin
                  stored_len_nxt = ann_len_r[16:0];
                  ready_nxt      = 1'b1;
                  status         = ST_ACCEPT;
                end else begin
                  status = ST_NOTJPEG;
                end
              end
              phase_nxt = PH_SYNC;
            end
          end
          default: begin
            if (rx_byte == sync_byte(sync_cnt_r)) begin
              sync_cnt_nxt = sync_cnt_r + 2'd1;
              if (sync_cnt_r == 2'd3) begin
                len_idx_nxt = '0;
                ann_len_nxt = '0;
                phase_nxt   = PH_LEN;
              end
            end else begin
              sync_cnt_nxt = (rx_byte == SYNC_BYTE_A) ? 2'd1 : 2'd0;
            end
          end
        endcase
      end
      CMD_CLEAR: ready_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SYNC;
      sync_cnt_r   <= '0;
      len_idx_r    <= '0;
      ann_len_r    <= '0;
      rx_cnt_r     <= '0;
      ready_r      <= 1'b0;
      stored_len_r <= '0;
    end else if (en) begin
      phase_r      <= phase_nxt;
      sync_cnt_r   <= sync_cnt_nxt;
      len_idx_r    <= len_idx_nxt;
      ann_len_r    <= ann_len_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      ready_r      <= ready_nxt;
      stored_len_r <= stored_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byte0_r <= byte0_nxt;
      byte1_r <= byte1_nxt;
    end
  end

  assign res.status = status;
  assign res.ready  = ready_nxt;
  assign res.length = stored_len_nxt;
  assign wr_en      = en && wr;
  assign wr_addr    = rx_cnt_r[AW-1:0];
  assign wr_data    = rx_byte;

  // ready only rises on a processed request
  a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ready_r) |-> $past(en))
    else $error("ready flag rose without a request");

  // payload count never reaches the buffer size inside a frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rx_cnt_r < CNT_MAX)
    else $error("payload count out of range");

endmodule
